/* rtl/core/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the block mean and median core.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

	localparam int VALUE_W   = 32;
	localparam int MEAN_W    = 40;
	localparam int MEDIAN_W  = 33;
	localparam int FRAC_W    = 8;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 80;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_WAIT
	} bmm_state_t;

	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic out_load;
	} bmm_cmd_t;

	typedef struct packed {
		logic last_item;
		logic div_last;
	} bmm_status_t;

endpackage

`default_nettype wire

/* rtl/core/bmm_ctrl.sv */
// ----------------------------------------------------------------------------
// bmm_ctrl
// Controller state machine: sequences loading, division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_ctrl
	import bmm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire bmm_status_t status,
	output bmm_cmd_t         cmd
);

	bmm_state_t state_q;
	bmm_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_LOAD: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && status.last_item) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/bmm_datapath.sv */
// ----------------------------------------------------------------------------
// bmm_datapath
// Insertion sort chain, running sum, radix-256 divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_datapath
	import bmm_pkg::*;
#(
	parameter int BLOCK_LEN = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [VALUE_W-1:0]   value,
	input  wire bmm_cmd_t             cmd,
	output bmm_status_t               status,
	output logic [MEAN_W-1:0]         mean_q8,
	output logic [MEDIAN_W-1:0]       median_x2
);

	localparam int CNT_W   = $clog2(BLOCK_LEN + 1);
	localparam int SUM_W   = VALUE_W + $clog2(BLOCK_LEN);
	localparam int DIV_W   = SUM_W + FRAC_W;
	localparam int DIG_W   = 8;
	localparam int NDIG    = (DIV_W + DIG_W - 1) / DIG_W;
	localparam int DIVP_W  = NDIG * DIG_W;
	localparam int DCNT_W  = $clog2(NDIG);
	localparam int RW      = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam int RSH     = $clog2(BLOCK_LEN);
	localparam int TRIAL_W = RW + DIG_W;
	localparam int RECIP_W = TRIAL_W + 1;
	localparam int PROD_W  = TRIAL_W + RECIP_W;
	localparam int RECIP   = (2 ** (TRIAL_W + RSH) + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int MID_HI  = BLOCK_LEN / 2;
	localparam int MID_LO  = (BLOCK_LEN > 1) ? (BLOCK_LEN / 2 - 1) : 0;
	localparam bit EVEN    = (BLOCK_LEN % 2) == 0;

	localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
	localparam logic [TRIAL_W-1:0] DIVISOR_C = TRIAL_W'(BLOCK_LEN);

	logic signed [VALUE_W-1:0] sorted_q [BLOCK_LEN];
	logic [BLOCK_LEN-1:0]      gt;
	logic [CNT_W-1:0]          count_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SUM_W-1:0]   sum_base;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [VALUE_W-1:0] value_s;

	logic [DIVP_W-1:0]  div_q;
	logic [RW-1:0]      rem_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic               neg_q;
	logic [SUM_W-1:0]   sum_mag;
	logic [TRIAL_W-1:0] trial;
	logic [PROD_W-1:0]  trial_prod;
	logic [DIG_W-1:0]   digit;
	logic [TRIAL_W-1:0] digit_mul;
	logic [TRIAL_W-1:0] trial_rem;
	logic [DIVP_W-1:0]  quot;
	logic [MEDIAN_W-1:0] median_d;

	assign value_s = $signed(value);

	genvar gi;
	generate
		for (gi = 0; gi < BLOCK_LEN; gi++) begin : g_cell
			logic signed [VALUE_W-1:0] shift_in;
			logic                      cell_we;

			assign gt[gi] = (count_q > CNT_W'(gi)) && (sorted_q[gi] > value_s);

			if (gi == 0) begin : g_head
				assign shift_in = value_s;
			end else begin : g_body
				assign shift_in = gt[gi-1] ? sorted_q[gi-1] : value_s;
			end

			assign cell_we = cmd.accept && (gt[gi] || (count_q == CNT_W'(gi)));

			always_ff @(posedge clk) begin
				if (cell_we) begin
					sorted_q[gi] <= shift_in;
				end
			end
		end
	endgenerate

	assign sum_base = (count_q == '0) ? '0 : sum_q;
	assign sum_next = sum_base + SUM_W'(value_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.accept) begin
			sum_q <= sum_next;
			if (count_q == CNT_W'(BLOCK_LEN - 1)) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign status.last_item = (count_q == CNT_W'(BLOCK_LEN - 1));
	assign status.div_last  = (div_cnt_q == DCNT_W'(NDIG - 1));

	// Each step divides the remainder and the next dividend byte by the block
	// length through a multiply by its rounded-up reciprocal, which is exact
	// for every partial dividend that can occur.
	assign sum_mag    = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign trial      = {rem_q, div_q[DIVP_W-1 -: DIG_W]};
	assign trial_prod = PROD_W'(trial) * PROD_W'(RECIP_C);
	assign digit      = trial_prod[TRIAL_W + RSH +: DIG_W];
	assign digit_mul  = TRIAL_W'(digit) * DIVISOR_C;
	assign trial_rem  = trial - digit_mul;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_q     <= DIVP_W'({sum_mag, {FRAC_W{1'b0}}});
			rem_q     <= '0;
			div_cnt_q <= '0;
			neg_q     <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			div_q     <= {div_q[DIVP_W-DIG_W-1:0], digit};
			rem_q     <= trial_rem[RW-1:0];
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	assign quot = neg_q ? (~div_q + DIVP_W'(1)) : div_q;

	always_comb begin
		if (EVEN) begin
			median_d = MEDIAN_W'(sorted_q[MID_LO]) + MEDIAN_W'(sorted_q[MID_HI]);
		end else begin
			median_d = MEDIAN_W'(sorted_q[MID_HI]) + MEDIAN_W'(sorted_q[MID_HI]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q8   <= quot[MEAN_W-1:0];
			median_x2 <= median_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/block_mean_and_median_core.sv */
// ----------------------------------------------------------------------------
// block_mean_and_median_core
// Mean (Q8, truncated toward zero) and twice the median of blocks of samples.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata fields (low bit up)             tuser  tlast
// s_axis   in   value[31:0]                           none   none
// m_axis   out  mean_q8[39:0], median_x2[72:40], pad  none   none
//
// Samples are taken one per cycle while the controller is in its load state, BLOCK_LEN per block, into the sort chain.
// The divider then takes a setup step (ST_PREP) and ceil((40 + clog2(BLOCK_LEN)) / 8) steps (6 for 15),
// one quotient byte per cycle, and the result then loads into the output register once that register is free.
// The next block loads while the result waits; a finished block holds if it is untaken.
// Reset clears the state machine, sample count, sum and output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_and_median_core
	import bmm_pkg::*;
#(
	parameter int BLOCK_LEN = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // value[31:0]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata   // mean_q8[39:0], median_x2[72:40]
);

	bmm_cmd_t            cmd;
	bmm_status_t         status;
	logic [MEAN_W-1:0]   mean_q8;
	logic [MEDIAN_W-1:0] median_x2;

	bmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bmm_datapath #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata[VALUE_W-1:0]),
		.cmd       (cmd),
		.status    (status),
		.mean_q8   (mean_q8),
		.median_x2 (median_x2)
	);

	assign m_tdata = {{(M_TDATA_W - MEAN_W - MEDIAN_W){1'b0}}, median_x2, mean_q8};

endmodule

`default_nettype wire

/* rtl/core/bmm_checker.sv */
// ----------------------------------------------------------------------------
// bmm_checker
// Port-level checks for the block mean and median core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_checker
	import bmm_pkg::*;
#(
	parameter int BLOCK_LEN = 15
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	localparam bit ODD = (BLOCK_LEN % 2) == 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while samples were being taken");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("input stopped without a completing sample transfer");

	a_odd_median: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ODD |-> !m_tdata[MEAN_W])
		else $error("odd block gave an odd doubled median");

endmodule

bind block_mean_and_median_core bmm_checker #(
	.BLOCK_LEN (BLOCK_LEN)
) u_bmm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for block_mean_and_median_core. Samples stream in
// through the slave port while a local predictor keeps the current block,
// its exact sum and, at each completed block, the Q8 mean and twice the
// median. Every result transfer on the master port is compared field by
// field against the oldest predicted result. Both ports idle at random, the
// receiver holds off for a long stretch so that the core fills up, and the
// sender pauses until every pending result has come back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import bmm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_LEN    = 15;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE_CYCLES = 100;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	typedef enum int {
		MIX_FULL,
		MIX_SMALL,
		MIX_EXTREME,
		MIX_CONSTANT,
		MIX_REPEATS
	} sample_mix_t;

	typedef struct {
		logic signed [MEAN_W-1:0]   mean_q8;
		logic signed [MEDIAN_W-1:0] median_x2;
	} block_stats_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // value[31:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // mean_q8[39:0], median_x2[72:40], pad

	block_stats_t stats_expected[$];

	longint signed block_samples[BLOCK_LEN];
	longint signed block_sum;
	int            block_fill;

	int  err_count;
	int  samples_sent;
	int  stats_checked;
	int  cycle_count;
	int  hold_cycles_req;
	bit  src_gaps_on;
	bit  snk_stalls_on;

	block_mean_and_median_core #(
		.BLOCK_LEN(BLOCK_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Adds one accepted sample to the current block and predicts the result
	// when the block is complete.
	function automatic void fold_sample(logic signed [VALUE_W-1:0] value);
		longint signed sorted[BLOCK_LEN];
		longint signed key;
		longint signed scaled;
		longint signed twice_mid;
		block_stats_t  stats;
		int            j;
		block_samples[block_fill] = longint'(value);
		block_sum += longint'(value);
		block_fill++;
		if (block_fill == BLOCK_LEN) begin
			sorted = block_samples;
			for (int i = 1; i < BLOCK_LEN; i++) begin
				key = sorted[i];
				j = i;
				while (j > 0 && sorted[j-1] > key) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = key;
			end
			scaled = (block_sum * 256) / BLOCK_LEN;
			if (BLOCK_LEN % 2 == 0) begin
				twice_mid = sorted[BLOCK_LEN/2-1] + sorted[BLOCK_LEN/2];
			end else begin
				twice_mid = 2 * sorted[BLOCK_LEN/2];
			end
			stats.mean_q8   = scaled[MEAN_W-1:0];
			stats.median_x2 = twice_mid[MEDIAN_W-1:0];
			stats_expected.push_back(stats);
			block_fill = 0;
			block_sum  = 0;
		end
	endfunction

	task automatic send_sample(input logic signed [VALUE_W-1:0] value);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		fold_sample(value);
		samples_sent++;
	endtask

	// Lowers valid, then waits until no result is pending or the wait limit runs out.
	task automatic wait_for_results(input int limit);
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (stats_expected.size() != 0 && waited < limit);
	endtask

	// Receiver: random stalls per transfer, an optional long hold-off, and the
	// comparison against the oldest predicted result.
	initial begin
		int           stall;
		block_stats_t want;
		logic signed [MEAN_W-1:0]   got_mean;
		logic signed [MEDIAN_W-1:0] got_median;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles_req > 0) begin
				stall = hold_cycles_req;
				hold_cycles_req = 0;
			end else begin
				stall = snk_stalls_on ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got_mean   = m_tdata[MEAN_W-1:0];
			got_median = m_tdata[MEAN_W +: MEDIAN_W];
			if (stats_expected.size() == 0) begin
				$error("Unexpected result transfer: mean_q8 %0d, median_x2 %0d",
					got_mean, got_median);
				err_count++;
			end else begin
				want = stats_expected.pop_front();
				stats_checked++;
				if (got_mean !== want.mean_q8) begin
					$error("mean_q8 mismatch: expected %0d, actual %0d",
						want.mean_q8, got_mean);
					err_count++;
				end
				if (got_median !== want.median_x2) begin
					$error("median_x2 mismatch: expected %0d, actual %0d",
						want.median_x2, got_median);
					err_count++;
				end
			end
		end
	end

	function automatic logic signed [VALUE_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return VALUE_MIN;
			1: return VALUE_MAX;
			2: return '0;
			3: return -1;
			4: return 1;
			default: return VALUE_MIN + 1;
		endcase
	endfunction

	task automatic test_extreme_samples();
		logic signed [VALUE_W-1:0] mixed[10];
		mixed = '{VALUE_MAX, -1, 0, 1, VALUE_MAX, VALUE_MIN + 1, VALUE_MAX - 1, -2, 2, 0};
		src_gaps_on   = 1'b0;
		snk_stalls_on = 1'b0;
		for (int i = 0; i < BLOCK_LEN; i++) begin
			send_sample(VALUE_MIN);
		end
		foreach (mixed[i]) begin
			send_sample(mixed[i]);
		end
	endtask

	task automatic test_random_blocks(input int n_items);
		sample_mix_t               mix;
		logic signed [VALUE_W-1:0] constant_value;
		logic signed [VALUE_W-1:0] repeat_pool[3];
		logic signed [VALUE_W-1:0] value;
		mix = MIX_FULL;
		constant_value = '0;
		repeat_pool = '{default: '0};
		for (int n = 0; n < n_items; n++) begin
			if (n % 40 == 0) begin
				src_gaps_on   = ($urandom_range(0, 3) != 0);
				snk_stalls_on = ($urandom_range(0, 3) != 0);
			end
			if (block_fill == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: mix = MIX_FULL;
					4, 5:       mix = MIX_SMALL;
					6:          mix = MIX_EXTREME;
					7:          mix = MIX_CONSTANT;
					default:    mix = MIX_REPEATS;
				endcase
				constant_value = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
				foreach (repeat_pool[i]) begin
					repeat_pool[i] = $urandom();
				end
			end
			case (mix)
				MIX_SMALL:    value = $signed($urandom_range(0, 16)) - 8;
				MIX_EXTREME:  value = pick_extreme();
				MIX_CONSTANT: value = constant_value;
				MIX_REPEATS:  value = repeat_pool[$urandom_range(0, 2)];
				default:      value = $urandom();
			endcase
			send_sample(value);
			if ($urandom_range(0, 149) == 0) begin
				wait_for_results(DRAIN_LIMIT);
			end
		end
	endtask

	// The receiver holds off while the sender streams without gaps, so the
	// core finishes one block, loads the next and then stalls its input.
	task automatic test_output_backpressure();
		src_gaps_on     = 1'b0;
		snk_stalls_on   = 1'b0;
		hold_cycles_req = 300;
		for (int i = 0; i < 4 * BLOCK_LEN; i++) begin
			send_sample($urandom());
		end
		wait_for_results(DRAIN_LIMIT);
	endtask

	task automatic test_drain_pause();
		src_gaps_on   = 1'b1;
		snk_stalls_on = 1'b1;
		for (int i = 0; i < BLOCK_LEN + 3; i++) begin
			send_sample($urandom());
		end
		wait_for_results(DRAIN_LIMIT);
		for (int i = 0; i < BLOCK_LEN - 3; i++) begin
			send_sample($urandom());
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		err_count       = 0;
		samples_sent    = 0;
		stats_checked   = 0;
		cycle_count     = 0;
		hold_cycles_req = 0;
		src_gaps_on     = 1'b0;
		snk_stalls_on   = 1'b0;
		block_samples   = '{default: 0};
		block_sum       = 0;
		block_fill      = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_samples();
		test_output_backpressure();
		test_drain_pause();
		test_random_blocks(735);

		wait_for_results(DRAIN_LIMIT);
		if (stats_expected.size() != 0) begin
			$error("%0d predicted results never arrived", stats_expected.size());
			err_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Streamed %0d samples and checked %0d block results (mean and median).",
			samples_sent, stats_checked);
		$display("Runs included extreme and constant blocks, a long output hold-off and drain pauses.");
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/core/bmm_pkg.sv
rtl/core/bmm_ctrl.sv
rtl/core/bmm_datapath.sv
rtl/core/block_mean_and_median_core.sv
rtl/core/bmm_checker.sv
test/tb_top.sv
